/* src/fmtr_pkg.sv */
// Package for the frontier mate transition ranker: widths, types and word helpers.
package fmtr_pkg;

  localparam int unsigned WORD_W   = 56;
  localparam int unsigned SYMS     = 28;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CNT_W    = 45;
  localparam int unsigned RANK_W   = 40;
  localparam int unsigned ACC_W    = 52;
  localparam int unsigned HGT_W    = 7;
  localparam int unsigned MAX_WIDTH_DEF = 28;
  localparam int unsigned FW_RESET = 15;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_MAIN  = 2'd1,
    KIND_BLOCK = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  localparam logic [1:0] SYM_NONE  = 2'd0;
  localparam logic [1:0] SYM_RIGHT = 2'd1;
  localparam logic [1:0] SYM_LEFT  = 2'd2;

  // Control bundle shared by every cell of the count column.
  typedef struct packed {
    logic                    load;
    logic                    step;
    logic signed [HGT_W-1:0] h;
    logic [1:0]              sym;
  } cell_ctl_t;

  function automatic logic [WORD_W-1:0] low_mask(input logic [POS_W-1:0] n);
    logic [WORD_W:0] one;
    one = (WORD_W+1)'(1) << {n, 1'b0};
    return WORD_W'(one - (WORD_W+1)'(1));
  endfunction

  function automatic logic [1:0] sym_get(input logic [WORD_W-1:0] w,
                                         input logic [POS_W-1:0] k);
    return 2'(w >> {k, 1'b0});
  endfunction

  function automatic logic [WORD_W-1:0] sym_put(input logic [WORD_W-1:0] w,
                                                input logic [POS_W-1:0] k,
                                                input logic [1:0] v);
    logic [WORD_W-1:0] z;
    z = WORD_W'(3) << {k, 1'b0};
    return (w & ~z) | (WORD_W'(v) << {k, 1'b0});
  endfunction

  function automatic logic [WORD_W-1:0] pair_put(input logic [WORD_W-1:0] w,
                                                 input logic [POS_W-1:0] p,
                                                 input logic [3:0] v);
    logic [POS_W-1:0] b;
    logic [WORD_W-1:0] z;
    b = p - POS_W'(1);
    z = WORD_W'(15) << {b, 1'b0};
    return (w & ~z) | (WORD_W'(v) << {b, 1'b0});
  endfunction

  function automatic logic [WORD_W-1:0] drop_sym(input logic [WORD_W-1:0] w,
                                                 input logic [POS_W-1:0] k);
    logic [WORD_W-1:0] lo;
    lo = low_mask(k);
    return ((w & ~lo) >> 2) | (w & lo);
  endfunction

  function automatic logic [WORD_W-1:0] add_empty(input logic [WORD_W-1:0] w,
                                                  input logic [POS_W-1:0] k);
    logic [WORD_W-1:0] lo;
    lo = low_mask(k);
    return (w & lo) | ((w & ~lo) << 2);
  endfunction

endpackage

/* src/fmtr_cell.sv */
// One cell of the lattice-path count column with its rank tap.
`default_nettype none
module fmtr_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                       clk,
  input  wire fmtr_pkg::cell_ctl_t        ctl,
  input  wire logic [fmtr_pkg::CNT_W-1:0] below,
  input  wire logic [fmtr_pkg::CNT_W-1:0] above,
  output logic      [fmtr_pkg::CNT_W-1:0] count,
  output logic      [fmtr_pkg::CNT_W-1:0] tap_a,
  output logic      [fmtr_pkg::CNT_W-1:0] tap_b
);
  import fmtr_pkg::*;

  logic hit_a;
  logic hit_b;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      count <= (IDX == 0) ? CNT_W'(1) : '0;
    end else if (ctl.step) begin
      count <= below + count + above;
    end
  end

  // Tap a takes count at the current height, tap b the count one below it.
  assign hit_a = (ctl.sym != SYM_NONE) && (ctl.h == HGT_W'(IDX));
  assign hit_b = (ctl.sym[1]) && (ctl.h > 0) && (ctl.h == HGT_W'(IDX + 1));
  assign tap_a = hit_a ? count : '0;
  assign tap_b = hit_b ? count : '0;

endmodule
`default_nettype wire

/* src/frontier_mate_transition_ranker.sv */
// Top level of the frontier mate transition ranker.
`default_nettype none
// Channel   Dir  Handshake              Contents
// s_axis    in   tvalid/tready          tuser req_type, tdata word and position
// m_axis    out  tvalid/tready          tuser target_kind, tdata rank and overflow
// cfg       in   cfg_we                 frontier_width
//
// A transaction is accepted in the idle state, then the left-left and right-right pairs run a bracket
// scan; the prepare and height states set up the class and starting height, the rank walk steps
// through the count cells over each symbol of the result class width, and the done state loads
// the output register.
// Reset is synchronous; it clears the controller and the output valid. A result waits
// in the output register while the next transaction is accepted; a stalled output
// holds the finished item.
module frontier_mate_transition_ranker #(
  parameter int unsigned MAX_WIDTH = fmtr_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: state_word [55:0], position [60:56], zero [63:61]
  input  wire logic [63:0] s_axis_tdata,
  // tuser: req_type [0]
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: target_rank [39:0], rank_overflow [40], zero [47:41]
  output logic [47:0]      m_axis_tdata,
  // tuser: target_kind [1:0]
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);
  import fmtr_pkg::*;

  localparam int unsigned NCELL = MAX_WIDTH + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_PREP, ST_HEIGHT, ST_RANK, ST_DONE
  } state_t;

  state_t              state;
  logic [4:0]          frontier_width;
  logic [WORD_W-1:0]   t;
  kind_t               kind;
  logic [POS_W-1:0]    p;
  logic [POS_W-1:0]    wid;
  logic [POS_W-1:0]    cw;
  logic [POS_W-1:0]    q;
  logic [POS_W-1:0]    s;
  logic                scan_up;
  logic                pgone;
  logic [POS_W-1:0]    pos;
  logic signed [HGT_W-1:0] hreg;
  logic [ACC_W-1:0]    rank;

  // Incoming fields and the clamped width.
  logic [WORD_W-1:0]   in_word;
  logic [POS_W-1:0]    in_pos;
  logic [POS_W-1:0]    w_eff;
  logic [WORD_W-1:0]   m_word;
  logic [3:0]          pr;
  logic                in_range;

  assign in_word = s_axis_tdata[55:0];
  assign in_pos  = s_axis_tdata[60:56];

  always_comb begin
    if (frontier_width < 5'd2) begin
      w_eff = POS_W'(2);
    end else if (frontier_width > 5'(MAX_WIDTH)) begin
      w_eff = POS_W'(MAX_WIDTH);
    end else begin
      w_eff = frontier_width;
    end
  end

  assign m_word   = in_word & low_mask(w_eff);
  assign pr       = 4'(m_word >> {in_pos - POS_W'(1), 1'b0});
  assign in_range = (in_pos >= POS_W'(1)) && (in_pos <= w_eff - POS_W'(1));

  // Start of a transaction: the rewritten word, its class and where the scan begins.
  logic [WORD_W-1:0] t_init;
  kind_t             kind_init;
  state_t            state_init;
  logic [POS_W-1:0]  q_init;
  logic              up_init;
  logic              pgone_init;

  always_comb begin
    t_init     = m_word;
    kind_init  = KIND_NONE;
    state_init = ST_PREP;
    q_init     = in_pos - POS_W'(1);
    up_init    = 1'b0;
    pgone_init = 1'b0;
    if (in_range) begin
      if (s_axis_tuser[0]) begin
        t_init    = add_empty(in_word & low_mask(w_eff - POS_W'(1)), in_pos);
        kind_init = KIND_MAIN;
      end else begin
        unique case (pr)
          4'h0: begin
            t_init    = pair_put(m_word, in_pos, 4'h9);
            kind_init = KIND_MAIN;
          end
          4'h1, 4'h2: begin
            if (in_pos == POS_W'(1)) begin
              t_init    = pair_put(m_word, in_pos, (pr == 4'h1) ? 4'h4 : 4'h8);
              kind_init = KIND_MAIN;
            end else begin
              t_init    = drop_sym(m_word, in_pos);
              kind_init = KIND_BLOCK;
            end
          end
          4'h4: begin
            t_init    = pair_put(m_word, in_pos, 4'h1);
            kind_init = KIND_MAIN;
          end
          4'h8: begin
            t_init    = pair_put(m_word, in_pos, 4'h2);
            kind_init = KIND_MAIN;
          end
          4'ha: begin
            t_init     = pair_put(m_word, in_pos, 4'h0);
            state_init = ST_SCAN;
          end
          4'h5: begin
            t_init     = pair_put(m_word, in_pos, 4'h0);
            q_init     = in_pos;
            up_init    = 1'b1;
            state_init = ST_SCAN;
          end
          4'h6: begin
            t_init     = pair_put(m_word, in_pos, 4'h0);
            pgone_init = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Bracket scan step.
  logic [POS_W-1:0] q_nx;
  logic [1:0]       v_scan;
  logic [POS_W-1:0] s_nx;
  logic             scan_fail;

  assign scan_fail = scan_up ? (q + POS_W'(1) >= wid) : (q == '0);
  assign q_nx      = scan_up ? q + POS_W'(1) : q - POS_W'(1);
  assign v_scan    = sym_get(t, q_nx);
  always_comb begin
    s_nx = s;
    if (v_scan == SYM_LEFT) begin
      s_nx = scan_up ? s - POS_W'(1) : s + POS_W'(1);
    end else if (v_scan == SYM_RIGHT) begin
      s_nx = scan_up ? s + POS_W'(1) : s - POS_W'(1);
    end
  end

  // Starting height: one plus lefts minus rights over the class width.
  logic [SYMS-1:0] is_l;
  logic [SYMS-1:0] is_r;
  logic signed [HGT_W-1:0] htot;
  always_comb begin
    for (int k = 0; k < SYMS; k++) begin
      is_l[k] = (t[2*k +: 2] == SYM_LEFT)  && (POS_W'(k) < cw);
      is_r[k] = (t[2*k +: 2] == SYM_RIGHT) && (POS_W'(k) < cw);
    end
    htot = HGT_W'(1) + HGT_W'($countones(is_l)) - HGT_W'($countones(is_r));
  end

  // Rank walk: symbol at pos and the height it is ranked at.
  logic [1:0]              sym_cur;
  logic signed [HGT_W-1:0] h_use;
  assign sym_cur = sym_get(t, pos);
  always_comb begin
    h_use = hreg;
    if (sym_cur == SYM_LEFT) begin
      h_use = hreg - HGT_W'(1);
    end else if (sym_cur == SYM_RIGHT) begin
      h_use = hreg + HGT_W'(1);
    end
  end

  // Count column: cell h holds count[pos][h]; each step moves to the next width.
  cell_ctl_t        ctl;
  logic [CNT_W-1:0] cnt   [NCELL];
  logic [CNT_W-1:0] tap_a [NCELL];
  logic [CNT_W-1:0] tap_b [NCELL];
  logic [CNT_W-1:0] sum_a;
  logic [CNT_W-1:0] sum_b;

  assign ctl.load = (state == ST_HEIGHT);
  assign ctl.step = (state == ST_RANK) && (pos != cw);
  assign ctl.h    = h_use;
  assign ctl.sym  = sym_cur;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fmtr_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .below ((i == 0) ? '0 : cnt[(i == 0) ? 0 : i-1]),
      .above ((i == NCELL-1) ? '0 : cnt[(i == NCELL-1) ? i : i+1]),
      .count (cnt[i]),
      .tap_a (tap_a[i]),
      .tap_b (tap_b[i])
    );
  end

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int i = 0; i < NCELL; i++) begin
      sum_a = sum_a | tap_a[i];
      sum_b = sum_b | tap_b[i];
    end
  end

  logic out_free;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      frontier_width <= 5'(FW_RESET);
    end else if (cfg_we) begin
      frontier_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // The done state reloads the output register itself.
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            wid     <= w_eff;
            p       <= in_pos;
            rank    <= '0;
            s       <= POS_W'(1);
            pgone   <= pgone_init;
            scan_up <= up_init;
            q       <= q_init;
            kind    <= kind_init;
            t       <= t_init;
            state   <= state_init;
          end
        end
        ST_SCAN: begin
          if (scan_fail) begin
            state <= ST_PREP;
          end else begin
            q <= q_nx;
            s <= s_nx;
            if (s_nx == '0) begin
              t     <= sym_put(t, q_nx, scan_up ? SYM_RIGHT : SYM_LEFT);
              pgone <= 1'b1;
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          // A removed pair either stays in the main class at the first cut or
          // collapses into a block word.
          if (pgone) begin
            if (p == POS_W'(1)) begin
              kind <= KIND_MAIN;
              cw   <= wid;
            end else begin
              t    <= drop_sym(t, p - POS_W'(1));
              kind <= KIND_BLOCK;
              cw   <= wid - POS_W'(1);
            end
            state <= ST_HEIGHT;
          end else if (kind == KIND_NONE) begin
            state <= ST_DONE;
          end else begin
            cw    <= (kind == KIND_MAIN) ? wid : wid - POS_W'(1);
            state <= ST_HEIGHT;
          end
        end
        ST_HEIGHT: begin
          hreg  <= htot;
          pos   <= '0;
          state <= ST_RANK;
        end
        ST_RANK: begin
          if (pos == cw) begin
            state <= ST_DONE;
          end else begin
            rank <= rank + ACC_W'(sum_a) + ACC_W'(sum_b);
            hreg <= h_use;
            pos  <= pos + POS_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= kind;
            m_axis_tdata  <= (kind != KIND_NONE) ?
                             {7'b0, (rank >= ACC_W'(cnt[1])), rank[RANK_W-1:0]} : '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/fmtr_checker.sv */
// Port-level checker for the frontier mate transition ranker, with its bind.
`default_nettype none
module fmtr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // No successor always reports a zero rank and no overflow.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == 2'd0) |-> (m_axis_tdata == 48'd0))
    else $error("no-successor result carries data");

  // The reserved kind code never appears.
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("reserved target kind");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // Reset empties the output register.
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind frontier_mate_transition_ranker fmtr_checker u_fmtr_checker (.*);
`default_nettype wire
